// ===== rtl/flash_program_erase_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// flash_program_erase_sequencer_unit_defines: assertion macros
// Shared property forms for the sequencer's own checks.
// ----------------------------------------------------------------------------
`ifndef FLASH_PROGRAM_ERASE_SEQUENCER_UNIT_DEFINES_SVH
`define FLASH_PROGRAM_ERASE_SEQUENCER_UNIT_DEFINES_SVH

// ante must be followed by cons in the same cycle
`define FPES_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// expr must never hold
`define FPES_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/fpes_pkg.sv =====
// ----------------------------------------------------------------------------
// fpes_pkg: flash sequencer shared definitions
// Codes, register defaults, descriptor and result types.
// ----------------------------------------------------------------------------
package fpes_pkg;

  localparam int ADDR_BITS  = 20;
  localparam int POS_W      = 21;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_IDX_W  = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // input function codes
  localparam logic [1:0] FUNC_HOST_BYTE = 2'd0;
  localparam logic [1:0] FUNC_READ_DATA = 2'd1;
  localparam logic [1:0] FUNC_ERASE     = 2'd2;
  localparam logic [1:0] FUNC_READ_ID   = 2'd3;

  // bus operations
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_WAIT   = 2'd2;
  localparam logic [1:0] OP_STATUS = 2'd3;

  // status codes
  localparam logic [2:0] ST_BYTE_OK      = 3'd0;
  localparam logic [2:0] ST_NO_SPACE     = 3'd1;
  localparam logic [2:0] ST_PROG_FAILED  = 3'd2;
  localparam logic [2:0] ST_ZERO_FAILED  = 3'd3;
  localparam logic [2:0] ST_ERASE_FAILED = 3'd4;
  localparam logic [2:0] ST_ERASE_DONE   = 3'd5;
  localparam logic [2:0] ST_ID_DONE      = 3'd6;

  // chip commands and data patterns
  localparam logic [7:0] CMD_RESET          = 8'hFF;
  localparam logic [7:0] CMD_READ_ID        = 8'h90;
  localparam logic [7:0] CMD_PROGRAM        = 8'h40;
  localparam logic [7:0] CMD_PROGRAM_VERIFY = 8'hC0;
  localparam logic [7:0] CMD_ERASE          = 8'h20;
  localparam logic [7:0] CMD_ERASE_VERIFY   = 8'hA0;
  localparam logic [7:0] ERASED_BYTE        = 8'hFF;
  localparam logic [7:0] ZERO_BYTE          = 8'h00;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROM_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROG_PULSE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERIFY_WAIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_PULSE   = 3'd5;

  // register defaults
  localparam logic [POS_W-1:0] ROM_SIZE_RST    = 21'd1048576;
  localparam logic [7:0]       RETRY_LIMIT_RST = 8'd25;
  localparam logic [11:0]      ERASE_LIMIT_RST = 12'd1000;
  localparam logic [7:0]       PROG_PULSE_RST  = 8'd10;
  localparam logic [7:0]       VERIFY_WAIT_RST = 8'd6;
  localparam logic [15:0]      ERASE_PULSE_RST = 16'd10000;

  // bus sequence segments, issued in this order
  localparam int NSEG      = 7;
  localparam int SEG_IDX_W = 3;
  localparam logic [SEG_IDX_W-1:0] SEG_RESET  = 3'd0;
  localparam logic [SEG_IDX_W-1:0] SEG_ERASE  = 3'd1;
  localparam logic [SEG_IDX_W-1:0] SEG_VERIFY = 3'd2;
  localparam logic [SEG_IDX_W-1:0] SEG_PROG   = 3'd3;
  localparam logic [SEG_IDX_W-1:0] SEG_STAT   = 3'd4;
  localparam logic [SEG_IDX_W-1:0] SEG_ID     = 3'd5;
  localparam logic [SEG_IDX_W-1:0] SEG_ID_LO  = 3'd6;

  typedef struct packed {
    logic [POS_W-1:0] rom_size;
    logic [7:0]       retry_limit;
    logic [11:0]      erase_limit;
    logic [7:0]       prog_pulse_us;
    logic [7:0]       verify_wait_us;
    logic [15:0]      erase_pulse_us;
  } cfg_t;

  typedef struct packed {
    logic [NSEG-1:0]      segs;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           data;
    logic [2:0]           status;
    logic [15:0]          dev_id;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_port_t;

  typedef struct packed {
    logic [1:0]           bus_op;
    logic [ADDR_BITS-1:0] bus_addr;
    logic [7:0]           bus_data;
    logic [15:0]          wait_us;
    logic [2:0]           status;
    logic [15:0]          device_id;
    logic                 last;
  } res_t;

endpackage

// ===== rtl/fpes_in_if.sv =====
// ----------------------------------------------------------------------------
// fpes_in_if: request channel
// Host bytes, chip read data, erase and identify requests.
// ----------------------------------------------------------------------------
interface fpes_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       last_of_write;

  modport source (output valid, func, data_byte, last_of_write, input ready);
  modport sink   (input valid, func, data_byte, last_of_write, output ready);
endinterface

// ===== rtl/fpes_out_if.sv =====
// ----------------------------------------------------------------------------
// fpes_out_if: result channel
// Bus writes, bus reads, waits and status reports.
// ----------------------------------------------------------------------------
interface fpes_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     bus_op;
  logic [fpes_pkg::ADDR_BITS-1:0] bus_addr;
  logic [7:0]                     bus_data;
  logic [15:0]                    wait_us;
  logic [2:0]                     status;
  logic [15:0]                    device_id;
  logic                           last;

  modport source (output valid, bus_op, bus_addr, bus_data, wait_us, status, device_id,
                  last, input ready);
  modport sink   (input valid, bus_op, bus_addr, bus_data, wait_us, status, device_id,
                  last, output ready);
endinterface

// ===== rtl/flash_program_erase_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// flash_program_erase_sequencer_unit: flash program, erase and identify sequencer
// Accepted items go through the queue and the back sequencer into the registered result stage.
// The back sequencer issues one bus operation per cycle while res.ready does not stall it.
// Reset: synchronous rst clears sequencing state and loads register defaults.
// ----------------------------------------------------------------------------
`include "flash_program_erase_sequencer_unit_defines.svh"

module flash_program_erase_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fpes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpes_pkg::CFG_DATA_W-1:0] cfg_data,
  fpes_in_if.sink                         cmd,
  fpes_out_if.source                      res
);

  fpes_pkg::q_port_t q_wr;
  fpes_pkg::q_port_t q_head;
  fpes_pkg::cfg_t    cfg;
  logic              q_full;
  logic              q_pop;

  fpes_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .cfg       (cfg)
  );

  fpes_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .full (q_full),
    .head (q_head),
    .pop  (q_pop)
  );

  fpes_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (q_head),
    .pop  (q_pop),
    .cfg  (cfg),
    .res  (res)
  );

  `FPES_ASSERT_NEVER(a_queue_no_overflow, q_wr.valid && q_full, "descriptor queued while full")
  `FPES_ASSERT_IMPLY(a_status_ends_item, res.valid && (res.bus_op == fpes_pkg::OP_STATUS), res.last, "status report not last of its transaction")
  `FPES_ASSERT_IMPLY(a_read_ends_item, res.valid && (res.bus_op == fpes_pkg::OP_READ), res.last, "bus read not last of its transaction")

endmodule

// ===== rtl/fpes_queue.sv =====
// ----------------------------------------------------------------------------
// fpes_queue: descriptor queue
// Short register queue between the classifier and the bus sequencer.
// ----------------------------------------------------------------------------
module fpes_queue (
  input  logic              clk,
  input  logic              rst,
  input  fpes_pkg::q_port_t wr,
  output logic              full,
  output fpes_pkg::q_port_t head,
  input  logic              pop
);

  localparam int CNT_W = fpes_pkg::QPTR_W + 1;

  fpes_pkg::desc_t             entries [fpes_pkg::QUEUE_DEPTH];
  logic [fpes_pkg::QPTR_W-1:0] wptr;
  logic [fpes_pkg::QPTR_W-1:0] rptr;
  logic [CNT_W-1:0]            count;
  logic                        push;
  logic                        do_pop;

  assign full      = (count == CNT_W'(fpes_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.desc  = entries[rptr];
  assign push      = wr.valid && !full;
  assign do_pop    = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == fpes_pkg::QPTR_W'(fpes_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == fpes_pkg::QPTR_W'(fpes_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wr.desc;
    end
  end

endmodule

// ===== rtl/fpes_front.sv =====
// ----------------------------------------------------------------------------
// fpes_front: request classifier
// Holds the configuration and sequencing state, decides per transaction
// which bus sequence segments follow and queues them as one descriptor.
// ----------------------------------------------------------------------------
module fpes_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [fpes_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpes_pkg::CFG_DATA_W-1:0]  cfg_data,
  fpes_in_if.sink                          cmd,
  input  logic                             q_full,
  output fpes_pkg::q_port_t                q_wr,
  output fpes_pkg::cfg_t                   cfg
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PROG,
    PH_ZERO,
    PH_VERIFY,
    PH_IDHI,
    PH_IDLO
  } phase_t;

  typedef struct packed {
    logic [fpes_pkg::POS_W-1:0] wpos;
    logic [fpes_pkg::POS_W-1:0] cur;
    logic [7:0]                 pend;
    logic [7:0]                 retry;
    logic [11:0]                ecnt;
    phase_t                     phase;
    logic                       bwait;
    logic [7:0]                 idhi;
    logic                       wend;
  } fst_t;

  typedef struct packed {
    fst_t            s;
    fpes_pkg::desc_t d;
  } ctx_t;

  fst_t st;
  ctx_t step_c;
  logic accept;

  function automatic ctx_t do_prog(ctx_t c, logic [7:0] b);
    ctx_t r;
    r = c;
    r.d.segs[fpes_pkg::SEG_PROG] = 1'b1;
    r.d.addr = c.s.cur[fpes_pkg::ADDR_BITS-1:0];
    r.d.data = b;
    return r;
  endfunction

  function automatic ctx_t do_stat(ctx_t c, logic [2:0] code, logic [15:0] id);
    ctx_t r;
    r = c;
    r.d.segs[fpes_pkg::SEG_STAT] = 1'b1;
    r.d.status = code;
    r.d.dev_id = id;
    return r;
  endfunction

  function automatic ctx_t host_start(ctx_t c, fpes_pkg::cfg_t cf);
    ctx_t r;
    r = c;
    if (r.s.cur >= cf.rom_size) begin
      r = do_stat(r, fpes_pkg::ST_NO_SPACE, '0);
      r.s.cur   = r.s.wpos;
      r.s.phase = PH_IDLE;
    end else begin
      r.s.retry = '0;
      r = do_prog(r, r.s.pend);
      r.s.phase = PH_PROG;
    end
    return r;
  endfunction

  function automatic ctx_t erase_ok(ctx_t c, fpes_pkg::cfg_t cf);
    ctx_t r;
    r = c;
    r.s.phase = PH_IDLE;
    r.s.cur   = r.s.wpos;
    if (r.s.bwait) begin
      r.s.bwait = 1'b0;
      r = host_start(r, cf);
    end else begin
      r = do_stat(r, fpes_pkg::ST_ERASE_DONE, '0);
    end
    return r;
  endfunction

  function automatic ctx_t erase_fail(ctx_t c, logic [2:0] code);
    ctx_t r;
    r = do_stat(c, code, '0);
    r.s.bwait = 1'b0;
    r.s.cur   = r.s.wpos;
    r.s.phase = PH_IDLE;
    return r;
  endfunction

  function automatic ctx_t verify_step(ctx_t c, fpes_pkg::cfg_t cf);
    ctx_t r;
    r = c;
    if (r.s.cur < cf.rom_size) begin
      r.d.segs[fpes_pkg::SEG_VERIFY] = 1'b1;
      r.d.addr  = r.s.cur[fpes_pkg::ADDR_BITS-1:0];
      r.s.phase = PH_VERIFY;
    end else begin
      r = erase_ok(r, cf);
    end
    return r;
  endfunction

  function automatic ctx_t erase_pass(ctx_t c, fpes_pkg::cfg_t cf);
    ctx_t r;
    r = c;
    if (r.s.ecnt >= cf.erase_limit) begin
      r = erase_fail(r, fpes_pkg::ST_ERASE_FAILED);
    end else begin
      r.s.ecnt = r.s.ecnt + 12'd1;
      r.d.segs[fpes_pkg::SEG_ERASE] = 1'b1;
      r = verify_step(r, cf);
    end
    return r;
  endfunction

  function automatic ctx_t zero_from_here(ctx_t c, fpes_pkg::cfg_t cf);
    ctx_t r;
    r = c;
    if (r.s.cur < cf.rom_size) begin
      r.s.retry = '0;
      r = do_prog(r, fpes_pkg::ZERO_BYTE);
      r.s.phase = PH_ZERO;
    end else begin
      r.s.cur  = '0;
      r.s.ecnt = '0;
      r = erase_pass(r, cf);
    end
    return r;
  endfunction

  function automatic ctx_t erase_start(ctx_t c, fpes_pkg::cfg_t cf);
    ctx_t r;
    r = c;
    r.d.segs[fpes_pkg::SEG_RESET] = 1'b1;
    r.s.cur = '0;
    r = zero_from_here(r, cf);
    return r;
  endfunction

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = !q_full;

  always_comb begin
    step_c.s = st;
    step_c.d = '0;
    if (st.phase == PH_IDLE) begin
      unique case (cmd.func)
        fpes_pkg::FUNC_HOST_BYTE: begin
          step_c.s.pend = cmd.data_byte;
          step_c.s.wend = cmd.last_of_write;
          if (st.wpos == '0 && st.cur == '0) begin
            step_c.s.bwait = 1'b1;
            step_c = erase_start(step_c, cfg);
          end else begin
            step_c = host_start(step_c, cfg);
          end
        end
        fpes_pkg::FUNC_READ_DATA: begin
        end
        fpes_pkg::FUNC_ERASE: begin
          step_c.s.bwait = 1'b0;
          step_c = erase_start(step_c, cfg);
        end
        fpes_pkg::FUNC_READ_ID: begin
          step_c.d.segs[fpes_pkg::SEG_ID] = 1'b1;
          step_c.s.phase = PH_IDHI;
        end
      endcase
    end else if (cmd.func == fpes_pkg::FUNC_READ_DATA) begin
      unique case (st.phase)
        PH_PROG: begin
          if (cmd.data_byte == st.pend) begin
            step_c = do_stat(step_c, fpes_pkg::ST_BYTE_OK, '0);
            step_c.s.cur = st.cur + 1'b1;
            if (st.wend) begin
              step_c.s.wpos = st.cur + 1'b1;
            end
            step_c.s.phase = PH_IDLE;
          end else if (st.retry >= cfg.retry_limit) begin
            step_c = do_stat(step_c, fpes_pkg::ST_PROG_FAILED, '0);
            step_c.s.cur   = st.wpos;
            step_c.s.phase = PH_IDLE;
          end else begin
            step_c.s.retry = st.retry + 8'd1;
            step_c = do_prog(step_c, st.pend);
          end
        end
        PH_ZERO: begin
          if (cmd.data_byte == fpes_pkg::ZERO_BYTE) begin
            step_c.s.cur = st.cur + 1'b1;
            step_c = zero_from_here(step_c, cfg);
          end else if (st.retry >= cfg.retry_limit) begin
            step_c = erase_fail(step_c, fpes_pkg::ST_ZERO_FAILED);
          end else begin
            step_c.s.retry = st.retry + 8'd1;
            step_c = do_prog(step_c, fpes_pkg::ZERO_BYTE);
          end
        end
        PH_VERIFY: begin
          if (cmd.data_byte == fpes_pkg::ERASED_BYTE) begin
            step_c.s.cur = st.cur + 1'b1;
            step_c = verify_step(step_c, cfg);
          end else begin
            step_c = erase_pass(step_c, cfg);
          end
        end
        PH_IDHI: begin
          step_c.s.idhi = cmd.data_byte;
          step_c.d.segs[fpes_pkg::SEG_ID_LO] = 1'b1;
          step_c.s.phase = PH_IDLO;
        end
        PH_IDLO: begin
          step_c = do_stat(step_c, fpes_pkg::ST_ID_DONE, {st.idhi, cmd.data_byte});
          step_c.s.phase = PH_IDLE;
        end
        default: begin
          step_c.s.phase = PH_IDLE;
        end
      endcase
    end
  end

  assign q_wr.valid = accept && (step_c.d.segs != '0);
  assign q_wr.desc  = step_c.d;

  always_ff @(posedge clk) begin
    if (rst) begin
      st                 <= '0;
      cfg.rom_size       <= fpes_pkg::ROM_SIZE_RST;
      cfg.retry_limit    <= fpes_pkg::RETRY_LIMIT_RST;
      cfg.erase_limit    <= fpes_pkg::ERASE_LIMIT_RST;
      cfg.prog_pulse_us  <= fpes_pkg::PROG_PULSE_RST;
      cfg.verify_wait_us <= fpes_pkg::VERIFY_WAIT_RST;
      cfg.erase_pulse_us <= fpes_pkg::ERASE_PULSE_RST;
    end else begin
      if (accept) begin
        st <= step_c.s;
      end
      // writes only land between operations
      if (cfg_we && st.phase == PH_IDLE) begin
        unique case (cfg_index)
          fpes_pkg::REG_ROM_SIZE:    cfg.rom_size       <= cfg_data[20:0];
          fpes_pkg::REG_RETRY_LIMIT: cfg.retry_limit    <= cfg_data[7:0];
          fpes_pkg::REG_ERASE_LIMIT: cfg.erase_limit    <= cfg_data[11:0];
          fpes_pkg::REG_PROG_PULSE:  cfg.prog_pulse_us  <= cfg_data[7:0];
          fpes_pkg::REG_VERIFY_WAIT: cfg.verify_wait_us <= cfg_data[7:0];
          fpes_pkg::REG_ERASE_PULSE: cfg.erase_pulse_us <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/fpes_back.sv =====
// ----------------------------------------------------------------------------
// fpes_back: bus sequencer
// Expands queued descriptors into bus operations, one per cycle while not
// stalled by res.ready, into a registered result stage.
// ----------------------------------------------------------------------------
module fpes_back (
  input  logic              clk,
  input  logic              rst,
  input  fpes_pkg::q_port_t head,
  output logic              pop,
  input  fpes_pkg::cfg_t    cfg,
  fpes_out_if.source        res
);

  logic                              busy;
  logic [fpes_pkg::NSEG-1:0]         rem;
  logic [2:0]                        step;
  fpes_pkg::desc_t                   dsc;
  fpes_pkg::res_t                    ob;
  logic                              ob_valid;

  logic [fpes_pkg::SEG_IDX_W-1:0]    seg;
  logic [fpes_pkg::NSEG-1:0]         rem_after;
  logic                              seg_done;
  logic                              last;
  logic                              out_free;
  logic                              advance;
  fpes_pkg::res_t                    op;

  function automatic logic [2:0] seg_last_step(logic [fpes_pkg::SEG_IDX_W-1:0] s);
    logic [2:0] n;
    unique case (s)
      fpes_pkg::SEG_RESET:  n = 3'd1;
      fpes_pkg::SEG_ERASE:  n = 3'd2;
      fpes_pkg::SEG_VERIFY: n = 3'd2;
      fpes_pkg::SEG_PROG:   n = 3'd5;
      fpes_pkg::SEG_STAT:   n = 3'd0;
      fpes_pkg::SEG_ID:     n = 3'd3;
      fpes_pkg::SEG_ID_LO:  n = 3'd1;
      default:              n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic fpes_pkg::res_t gen_op(logic [fpes_pkg::SEG_IDX_W-1:0] s,
                                            logic [2:0] k, fpes_pkg::desc_t d,
                                            fpes_pkg::cfg_t cf);
    fpes_pkg::res_t r;
    r = '0;
    unique case (s)
      fpes_pkg::SEG_RESET: begin
        r.bus_op   = fpes_pkg::OP_WRITE;
        r.bus_data = fpes_pkg::CMD_RESET;
      end
      fpes_pkg::SEG_ERASE: begin
        if (k == 3'd2) begin
          r.bus_op  = fpes_pkg::OP_WAIT;
          r.wait_us = cf.erase_pulse_us;
        end else begin
          r.bus_op   = fpes_pkg::OP_WRITE;
          r.bus_data = fpes_pkg::CMD_ERASE;
        end
      end
      fpes_pkg::SEG_VERIFY: begin
        unique case (k)
          3'd0: begin
            r.bus_op   = fpes_pkg::OP_WRITE;
            r.bus_addr = d.addr;
            r.bus_data = fpes_pkg::CMD_ERASE_VERIFY;
          end
          3'd1: begin
            r.bus_op  = fpes_pkg::OP_WAIT;
            r.wait_us = 16'(cf.verify_wait_us);
          end
          default: begin
            r.bus_op   = fpes_pkg::OP_READ;
            r.bus_addr = d.addr;
          end
        endcase
      end
      fpes_pkg::SEG_PROG: begin
        unique case (k)
          3'd0: begin
            r.bus_op   = fpes_pkg::OP_WRITE;
            r.bus_addr = d.addr;
            r.bus_data = fpes_pkg::CMD_PROGRAM;
          end
          3'd1: begin
            r.bus_op   = fpes_pkg::OP_WRITE;
            r.bus_addr = d.addr;
            r.bus_data = d.data;
          end
          3'd2: begin
            r.bus_op  = fpes_pkg::OP_WAIT;
            r.wait_us = 16'(cf.prog_pulse_us);
          end
          3'd3: begin
            r.bus_op   = fpes_pkg::OP_WRITE;
            r.bus_addr = d.addr;
            r.bus_data = fpes_pkg::CMD_PROGRAM_VERIFY;
          end
          3'd4: begin
            r.bus_op  = fpes_pkg::OP_WAIT;
            r.wait_us = 16'(cf.verify_wait_us);
          end
          default: begin
            r.bus_op   = fpes_pkg::OP_READ;
            r.bus_addr = d.addr;
          end
        endcase
      end
      fpes_pkg::SEG_STAT: begin
        r.bus_op    = fpes_pkg::OP_STATUS;
        r.status    = d.status;
        r.device_id = d.dev_id;
      end
      fpes_pkg::SEG_ID: begin
        unique case (k)
          3'd2: begin
            r.bus_op   = fpes_pkg::OP_WRITE;
            r.bus_data = fpes_pkg::CMD_READ_ID;
          end
          3'd3: begin
            r.bus_op = fpes_pkg::OP_READ;
          end
          default: begin
            r.bus_op   = fpes_pkg::OP_WRITE;
            r.bus_data = fpes_pkg::CMD_RESET;
          end
        endcase
      end
      fpes_pkg::SEG_ID_LO: begin
        if (k == 3'd0) begin
          r.bus_op   = fpes_pkg::OP_WRITE;
          r.bus_data = fpes_pkg::CMD_READ_ID;
        end else begin
          r.bus_op   = fpes_pkg::OP_READ;
          r.bus_addr = fpes_pkg::ADDR_BITS'(1);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // lowest pending segment goes first
  always_comb begin
    seg = '0;
    for (int i = fpes_pkg::NSEG - 1; i >= 0; i--) begin
      if (rem[i]) begin
        seg = fpes_pkg::SEG_IDX_W'(i);
      end
    end
  end

  assign rem_after = rem & ~(fpes_pkg::NSEG'(1) << seg);
  assign seg_done  = (step == seg_last_step(seg));
  assign last      = seg_done && (rem_after == '0);
  assign out_free  = !ob_valid || res.ready;
  assign advance   = busy && out_free;
  assign pop       = head.valid && (!busy || (advance && last));

  always_comb begin
    op      = gen_op(seg, step, dsc, cfg);
    op.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rem      <= '0;
      step     <= '0;
      ob_valid <= 1'b0;
    end else begin
      if (out_free) begin
        ob_valid <= advance;
      end
      if (advance) begin
        if (seg_done) begin
          step <= '0;
          rem  <= rem_after;
        end else begin
          step <= step + 3'd1;
        end
        if (last) begin
          busy <= 1'b0;
        end
      end
      if (pop) begin
        busy <= 1'b1;
        rem  <= head.desc.segs;
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ob <= op;
    end
    if (pop) begin
      dsc <= head.desc;
    end
  end

  assign res.valid     = ob_valid;
  assign res.bus_op    = ob.bus_op;
  assign res.bus_addr  = ob.bus_addr;
  assign res.bus_data  = ob.bus_data;
  assign res.wait_us   = ob.wait_us;
  assign res.status    = ob.status;
  assign res.device_id = ob.device_id;
  assign res.last      = ob.last;

endmodule
